// ===== design/mfd_pkg.sv =====
package mfd_pkg;

   // Standard identifiers that carry motor feedback: first id is slot 0.
   localparam logic [10:0] ID_FIRST = 11'h201;
   localparam logic [10:0] ID_LAST  = 11'h208;

   // Encoder unwrap: one turn is 8191 counts, a jump above half a turn wraps.
   localparam logic signed [15:0] COUNTS_PER_TURN = 16'sd8191;
   localparam logic signed [15:0] HALF_TURN       = 16'sd4096;

   // 360 degrees in Q.16, so that dividing by ratio_q8 * 8191 leaves Q.8.
   localparam logic [24:0] ANGLE_SCALE = 25'd23592960;

   // Large-type current: c * 20 / 16384 A in mA Q.8 is c * 625 / 2.
   localparam logic signed [25:0] CURRENT_SCALE = 26'sd625;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SMALL_COUNT = 2'd0;
   localparam logic [1:0] CSR_SMALL_RATIO = 2'd1;
   localparam logic [1:0] CSR_LARGE_RATIO = 2'd2;

   localparam logic [3:0]  SMALL_COUNT_RESET = 4'd0;
   localparam logic [15:0] SMALL_RATIO_RESET = 16'd9216;
   localparam logic [15:0] LARGE_RATIO_RESET = 16'd4916;

   // Divider sizing: the angle dividend is below 2^56, the divisor below 2^29.
   localparam int QUO_W = 56;
   localparam int DIV_W = 29;
   localparam int RPM_STEPS = 24;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV_RPM,
      ST_MUL,
      ST_DIV_ANG,
      ST_FINISH
   } state_type;

endpackage

// ===== design/motor_feedback_frame_decoder.sv =====
// Motor feedback frame decoder.
// The req channel carries one received bus frame or one clear command per beat.
// Frames that are extended, remote, outside ids 0x201..0x208 or beyond the
// motors in use are dropped without a result; a clear command zeroes one
// motor's running total and gives no result.
// A valid frame updates the motor's unwrapped encoder total and gives one
// rsp beat with the raw count, shaft speed, current, temperature, total and
// output shaft angle. Speed and angle come out of one shared restoring divider
// that retires one quotient bit per cycle and forms 24 quotient bits for the
// speed and 56 for the angle. A frame passes through setup, the speed division,
// the angle scaling, the angle division and the output load, and req_tready
// is high again in the same cycle that the result reaches the output register.
// The output register holds a finished result while rsp_tready is low; the
// next frame is then decoded up to its final step and waits there for the
// register to free up.
// Reset clears the per-motor counts and totals, returns the configuration
// registers to their default values and empties the output register.
module motor_feedback_frame_decoder
   import mfd_pkg::*;
#(
   parameter int MOTOR_SLOTS = 8
) (
   input  logic         clock,
   input  logic         reset,
   // req_tdata: std_id[10:0], payload[66:11], zero_slot[69:67], zeros[71:70]
   input  logic [71:0]  req_tdata,
   // req_tuser: func[0], is_extended[1], is_remote[2]
   input  logic [2:0]   req_tuser,
   input  logic         req_tvalid,
   output logic         req_tready,
   // rsp_tdata: slot[2:0], raw_count[18:3], shaft_rpm[34:19],
   // current_ma_q8[59:35], temperature[67:60], pulse_total[99:68],
   // angle_q8[139:100], zeros[143:140]
   output logic [143:0] rsp_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [15:0]  csr_wdata
);

   localparam int SLOT_W = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;
   localparam logic [3:0] SLOT_LIMIT = 4'(MOTOR_SLOTS);
   localparam logic [QUO_W-1:0] RPM_MAX = QUO_W'(32767);
   localparam logic [QUO_W-1:0] ANG_MAX = QUO_W'(40'sh7F_FFFF_FFFF);

   // Configuration.
   logic [3:0]  small_count_ff;
   logic [15:0] small_ratio_ff;
   logic [15:0] large_ratio_ff;

   // Per-motor state.
   logic [15:0] prev_count_ff [MOTOR_SLOTS];
   logic [31:0] run_total_ff  [MOTOR_SLOTS];

   // Sequencer and item registers.
   state_type state_ff, state_in;
   logic [2:0]               slot_ff, slot_in;
   logic signed [15:0]       raw_ff, raw_in;
   logic signed [15:0]       spd_ff, spd_in;
   logic signed [15:0]       cur_ff, cur_in;
   logic [7:0]               temp_ff, temp_in;
   logic                     large_ff, large_in;
   logic [15:0]              ratio_ff, ratio_in;
   logic [31:0]              pulse_ff, pulse_in;
   logic [31:0]              tot_mag_ff, tot_mag_in;
   logic [24:0]              ma_ff, ma_in;
   logic [15:0]              rpm_ff, rpm_in;

   // Shared divider.
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] divisor_ff, divisor_in;
   logic [5:0]       iter_ff, iter_in;
   logic             neg_ff, neg_in;
   logic             zero_num_ff, zero_num_in;

   // Output register.
   logic         rsp_valid_ff, rsp_valid_in;
   logic [143:0] rsp_data_ff, rsp_data_in;

   // Decode of the req beat.
   logic              accept;
   logic              func;
   logic              is_extended;
   logic              is_remote;
   logic [10:0]       std_id;
   logic [55:0]       payload;
   logic [2:0]        zero_slot;
   logic [2:0]        frame_slot;
   logic              frame_ok;
   logic              clear_ok;
   logic [SLOT_W-1:0] frame_idx;
   logic [SLOT_W-1:0] clear_idx;
   logic signed [15:0] new_count;
   logic signed [15:0] raw_step;
   logic signed [15:0] step;
   logic [31:0]        new_total;
   logic               frame_large;

   // Datapath helpers.
   logic [DIV_W:0]     shift_rem;
   logic [DIV_W:0]     sub_rem;
   logic               fits;
   logic [QUO_W-1:0]   quo_step;
   logic [DIV_W-1:0]   rem_step;
   logic [15:0]        spd_mag;
   logic signed [25:0] cur_x625;
   logic signed [25:0] cur_half;
   logic [QUO_W-1:0]   rpm_q;
   logic [15:0]        rpm_sat;
   logic [39:0]        ang_sat;

   assign func        = req_tuser[0];
   assign is_extended = req_tuser[1];
   assign is_remote   = req_tuser[2];
   assign std_id      = req_tdata[10:0];
   assign payload     = req_tdata[66:11];
   assign zero_slot   = req_tdata[69:67];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign frame_slot = 3'(std_id - ID_FIRST);
   assign frame_ok   = accept && !func && !is_extended && !is_remote &&
                       (std_id >= ID_FIRST) && (std_id <= ID_LAST) &&
                       ({1'b0, frame_slot} < SLOT_LIMIT);
   assign clear_ok   = accept && func && ({1'b0, zero_slot} < SLOT_LIMIT);
   assign frame_idx  = frame_slot[SLOT_W-1:0];
   assign clear_idx  = zero_slot[SLOT_W-1:0];

   // Multi-turn unwrap: the 16-bit difference is folded back by one turn
   // when it jumps by more than half a turn.
   assign new_count = $signed(payload[55:40]);
   assign raw_step  = new_count - $signed(prev_count_ff[frame_idx]);
   always_comb begin
      if (raw_step > HALF_TURN) begin
         step = raw_step - COUNTS_PER_TURN;
      end else if (raw_step < -HALF_TURN) begin
         step = raw_step + COUNTS_PER_TURN;
      end else begin
         step = raw_step;
      end
   end
   assign new_total   = run_total_ff[frame_idx] + 32'(step);
   assign frame_large = ({1'b0, frame_slot} >= small_count_ff);

   // One restoring step: bring down the next dividend bit, subtract if it fits.
   assign shift_rem = {rem_ff, quo_ff[QUO_W-1]};
   assign sub_rem   = shift_rem - {1'b0, divisor_ff};
   assign fits      = (shift_rem >= {1'b0, divisor_ff});
   assign rem_step  = fits ? sub_rem[DIV_W-1:0] : shift_rem[DIV_W-1:0];
   assign quo_step  = {quo_ff[QUO_W-2:0], fits};

   assign spd_mag  = spd_ff[15] ? 16'(-spd_ff) : 16'(spd_ff);
   assign cur_x625 = 26'(cur_ff) * CURRENT_SCALE;
   assign cur_half = (cur_x625 + 26'(cur_x625[25])) >>> 1;

   // A zero divisor leaves an all-ones quotient, which saturates in the sign
   // of the dividend; a zero dividend always gives zero.
   assign rpm_q = {{(QUO_W - RPM_STEPS){1'b0}}, quo_ff[RPM_STEPS-1:0]};
   always_comb begin
      if (zero_num_ff) begin
         rpm_sat = '0;
      end else if (neg_ff) begin
         rpm_sat = (rpm_q > RPM_MAX + QUO_W'(1)) ? 16'h8000 : 16'(-rpm_q[15:0]);
      end else begin
         rpm_sat = (rpm_q > RPM_MAX) ? 16'h7FFF : rpm_q[15:0];
      end
   end

   always_comb begin
      if (zero_num_ff) begin
         ang_sat = '0;
      end else if (neg_ff) begin
         ang_sat = (quo_ff > ANG_MAX + QUO_W'(1)) ? 40'h80_0000_0000 :
                   40'(-quo_ff[39:0]);
      end else begin
         ang_sat = (quo_ff > ANG_MAX) ? 40'h7F_FFFF_FFFF : quo_ff[39:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      raw_in       = raw_ff;
      spd_in       = spd_ff;
      cur_in       = cur_ff;
      temp_in      = temp_ff;
      large_in     = large_ff;
      ratio_in     = ratio_ff;
      pulse_in     = pulse_ff;
      tot_mag_in   = tot_mag_ff;
      ma_in        = ma_ff;
      rpm_in       = rpm_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      divisor_in   = divisor_ff;
      iter_in      = iter_ff;
      neg_in       = neg_ff;
      zero_num_in  = zero_num_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            if (frame_ok) begin
               slot_in  = frame_slot;
               raw_in   = new_count;
               spd_in   = $signed(payload[39:24]);
               cur_in   = $signed(payload[23:8]);
               temp_in  = frame_large ? payload[7:0] : 8'd0;
               large_in = frame_large;
               ratio_in = frame_large ? large_ratio_ff : small_ratio_ff;
               pulse_in = new_total;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            ma_in       = large_ff ? cur_half[24:0] : {cur_ff[15], cur_ff, 8'd0};
            tot_mag_in  = pulse_ff[31] ? 32'(-pulse_ff) : pulse_ff;
            quo_in      = {spd_mag, 8'd0, {(QUO_W - RPM_STEPS){1'b0}}};
            rem_in      = '0;
            divisor_in  = DIV_W'(ratio_ff);
            neg_in      = spd_ff[15];
            zero_num_in = (spd_ff == 16'sd0);
            iter_in     = 6'(RPM_STEPS - 1);
            state_in    = ST_DIV_RPM;
         end
         ST_DIV_RPM: begin
            quo_in  = quo_step;
            rem_in  = rem_step;
            iter_in = iter_ff - 6'd1;
            if (iter_ff == 6'd0) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            rpm_in      = rpm_sat;
            quo_in      = QUO_W'(tot_mag_ff) * QUO_W'(ANGLE_SCALE);
            rem_in      = '0;
            divisor_in  = DIV_W'({ratio_ff, 13'd0} - {13'd0, ratio_ff});
            neg_in      = pulse_ff[31];
            zero_num_in = (pulse_ff == 32'd0);
            iter_in     = 6'(QUO_W - 1);
            state_in    = ST_DIV_ANG;
         end
         ST_DIV_ANG: begin
            quo_in  = quo_step;
            rem_in  = rem_step;
            iter_in = iter_ff - 6'd1;
            if (iter_ff == 6'd0) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {4'd0, ang_sat, pulse_ff, temp_ff, ma_ff, rpm_ff,
                               raw_ff, slot_ff};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         small_count_ff <= SMALL_COUNT_RESET;
         small_ratio_ff <= SMALL_RATIO_RESET;
         large_ratio_ff <= LARGE_RATIO_RESET;
         for (int i = 0; i < MOTOR_SLOTS; i++) begin
            prev_count_ff[i] <= '0;
            run_total_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_SMALL_COUNT: small_count_ff <= csr_wdata[3:0];
               CSR_SMALL_RATIO: small_ratio_ff <= csr_wdata;
               CSR_LARGE_RATIO: large_ratio_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (frame_ok) begin
            prev_count_ff[frame_idx] <= 16'(new_count);
            run_total_ff[frame_idx]  <= new_total;
         end
         if (clear_ok) begin
            run_total_ff[clear_idx] <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      raw_ff      <= raw_in;
      spd_ff      <= spd_in;
      cur_ff      <= cur_in;
      temp_ff     <= temp_in;
      large_ff    <= large_in;
      ratio_ff    <= ratio_in;
      pulse_ff    <= pulse_in;
      tot_mag_ff  <= tot_mag_in;
      ma_ff       <= ma_in;
      rpm_ff      <= rpm_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      divisor_ff  <= divisor_in;
      iter_ff     <= iter_in;
      neg_ff      <= neg_in;
      zero_num_ff <= zero_num_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== verif/tb_motor_feedback_frame_decoder.sv =====
module tb_motor_feedback_frame_decoder
   import mfd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     CYCLE_LIMIT  = 500000;
   localparam int     SETTLE_CYCLES = 150;
   localparam int     HOLD_CYCLES  = 2500;
   localparam int     MAX_REPORTS  = 10;
   localparam longint ANGLE_Q16    = 360 * 65536;
   localparam longint ANGLE_MAX    = 64'sd549755813887;
   localparam longint ANGLE_MIN    = -64'sd549755813888;

   typedef struct packed {
      logic        func;
      logic        ext;
      logic        rem;
      logic [10:0] std_id;
      logic [55:0] payload;
      logic [2:0]  zero_slot;
   } frame_item_type;

   // Laid out so that the packed value matches rsp_tdata[139:0].
   typedef struct packed {
      logic [39:0] angle;
      logic [31:0] total;
      logic [7:0]  temp;
      logic [24:0] current;
      logic [15:0] rpm;
      logic [15:0] raw;
      logic [2:0]  slot;
   } feedback_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic [71:0]  req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [143:0] rsp_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_addr = '0;
   logic [15:0]  csr_wdata = '0;

   // Local copy of the configuration and of the per-motor state.
   logic [3:0]   cfg_small_count = SMALL_COUNT_RESET;
   logic [15:0]  cfg_small_ratio = SMALL_RATIO_RESET;
   logic [15:0]  cfg_large_ratio = LARGE_RATIO_RESET;
   logic [15:0]  last_count [8] = '{default: '0};
   logic [31:0]  pulse_sum  [8] = '{default: '0};

   frame_item_type  pending_frames[$];
   feedback_type    expected_feedback[$];
   frame_item_type  on_bus;
   feedback_type    got_fb;
   feedback_type    want_fb;
   logic [15:0]  gen_count [8] = '{default: '0};

   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   logic         hold_go = 1'b0;
   int           hold_left = 0;
   int           error_count = 0;
   int           cycle_count = 0;

   motor_feedback_frame_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint quotient_clamped(longint num, longint den, longint lo,
                                               longint hi);
      longint q;
      if (den == 0) begin
         if (num > 0) return hi;
         if (num < 0) return lo;
         return 0;
      end
      q = num / den;
      if (q > hi) return hi;
      if (q < lo) return lo;
      return q;
   endfunction

   // Applies one accepted beat to the local state and queues the result it causes.
   task automatic decode_feedback(input frame_item_type it);
      feedback_type      fb;
      logic [2:0]        s;
      bit                is_large;
      logic signed [15:0] diff;
      longint            cnt, spd, cur, delta_cnt, total, ratio, ma, rpm, ang;
      if (it.func) begin
         pulse_sum[it.zero_slot] = '0;
         return;
      end
      if (it.ext || it.rem || it.std_id < ID_FIRST || it.std_id > ID_LAST) return;
      s = 3'(it.std_id - ID_FIRST);
      cnt = longint'($signed(it.payload[55:40]));
      spd = longint'($signed(it.payload[39:24]));
      cur = longint'($signed(it.payload[23:8]));
      is_large = 4'(s) >= cfg_small_count;
      ratio = longint'(is_large ? cfg_large_ratio : cfg_small_ratio);
      ma = is_large ? cur * 625 / 2 : cur * 256;

      diff = cnt[15:0] - last_count[s];
      delta_cnt = longint'(diff);
      if (delta_cnt > HALF_TURN) delta_cnt -= COUNTS_PER_TURN;
      else if (delta_cnt < -HALF_TURN) delta_cnt += COUNTS_PER_TURN;
      pulse_sum[s] = pulse_sum[s] + delta_cnt[31:0];
      last_count[s] = cnt[15:0];
      total = longint'($signed(pulse_sum[s]));

      rpm = quotient_clamped(spd * 256, ratio, -32768, 32767);
      ang = quotient_clamped(total * ANGLE_Q16, ratio * COUNTS_PER_TURN, ANGLE_MIN,
                             ANGLE_MAX);
      fb.slot    = s;
      fb.raw     = cnt[15:0];
      fb.rpm     = rpm[15:0];
      fb.current = ma[24:0];
      fb.temp    = is_large ? it.payload[7:0] : 8'h00;
      fb.total   = pulse_sum[s];
      fb.angle   = ang[39:0];
      expected_feedback.push_back(fb);
   endtask

   function automatic string show_feedback(feedback_type f);
      return $sformatf("slot=%0d raw=%h rpm=%h ma=%h temp=%h total=%h angle=%h",
                       f.slot, f.raw, f.rpm, f.current, f.temp, f.total, f.angle);
   endfunction

   function automatic frame_item_type build_item(logic func, logic ext, logic rem,
                                                 logic [10:0] id, logic [55:0] pay,
                                                 logic [2:0] zs);
      frame_item_type it;
      it.func = func;
      it.ext = ext;
      it.rem = rem;
      it.std_id = id;
      it.payload = pay;
      it.zero_slot = zs;
      return it;
   endfunction

   // Request side: one beat per handshake, random gaps between beats.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) decode_feedback(on_bus);
         if (!req_tvalid || req_tready) begin
            if (pending_frames.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               on_bus = pending_frames.pop_front();
               req_tdata <= {2'b00, on_bus.zero_slot, on_bus.payload, on_bus.std_id};
               req_tuser <= {on_bus.rem, on_bus.ext, on_bus.func};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, counted down here.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_go) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Response side: checks every beat against the oldest expected result.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_fb = rsp_tdata[139:0];
            if (expected_feedback.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("unexpected rsp beat: %s", show_feedback(got_fb));
            end else begin
               want_fb = expected_feedback.pop_front();
               if (got_fb != want_fb) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS)
                     $display("rsp mismatch\n  expected %s\n  actual   %s",
                              show_feedback(want_fb), show_feedback(got_fb));
               end
            end
         end
         rsp_tready <= (hold_left == 0) && !hold_go &&
                       ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_motor_feedback_frame_decoder: FAIL");
         $finish;
      end
   end

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_SMALL_COUNT: cfg_small_count = val[3:0];
         CSR_SMALL_RATIO: cfg_small_ratio = val;
         CSR_LARGE_RATIO: cfg_large_ratio = val;
         default: ;
      endcase
   endtask

   // Frames that cause no result may still be in flight, so linger a while.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_frames.size() != 0 || req_tvalid || expected_feedback.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(input logic [3:0] count, input logic [15:0] s_ratio,
                            input logic [15:0] l_ratio, input int idle_pct,
                            input int stall_pct, input int n_items, input bit squeeze);
      frame_item_type it;
      int          made;
      int          pick;
      int          d;
      logic [2:0]  s;
      logic [15:0] c;
      write_csr(CSR_SMALL_COUNT, 16'(count));
      write_csr(CSR_SMALL_RATIO, s_ratio);
      write_csr(CSR_LARGE_RATIO, l_ratio);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      if (squeeze) begin
         @(posedge clock);
         hold_go <= 1'b1;
         @(posedge clock);
         hold_go <= 1'b0;
      end
      @(negedge clock);
      made = 0;
      while (made < n_items) begin
         pick = $urandom_range(99);
         it = build_item(1'b0, 1'b0, 1'b0, 11'($urandom), 56'({$urandom, $urandom}),
                         3'($urandom));
         if (pick < 70) begin
            // Well-formed frame; the count mostly moves like a real encoder.
            s = 3'($urandom);
            it.std_id = ID_FIRST + 11'(s);
            pick = $urandom_range(9);
            if (pick < 5) begin
               d = int'($urandom_range(1200)) - 600;
            end else if (pick < 7) begin
               d = int'($urandom_range(400)) + 3900;
               if ($urandom_range(1)) d = -d;
            end else begin
               d = int'($urandom_range(65535));
            end
            c = gen_count[s] + 16'(d);
            it.payload[55:40] = c;
            gen_count[s] = c;
         end else if (pick < 80) begin
            it.func = 1'b1;
            it.ext = 1'($urandom);
            it.rem = 1'($urandom);
         end else begin
            case ($urandom_range(3))
               0: begin
                  it.ext = 1'b1;
                  it.std_id = ID_FIRST + 11'($urandom_range(7));
               end
               1: begin
                  it.rem = 1'b1;
                  it.std_id = ID_FIRST + 11'($urandom_range(7));
               end
               2: it.std_id = $urandom_range(1) ? ID_FIRST - 11'd1 : ID_LAST + 11'd1;
               default: begin
                  it.ext = 1'($urandom);
                  it.rem = 1'($urandom);
               end
            endcase
         end
         pending_frames.push_back(it);
         made++;
      end
      wait_drained();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Unwrap boundaries, mainly on one motor, starting from the reset count of zero.
      pending_frames.push_back(build_item(1'b0, 1'b0, 1'b0, 11'h201,
                                          {16'h0000, 16'h7FFF, 16'h7FFF, 8'h7F}, 3'd0));
      pending_frames.push_back(build_item(1'b0, 1'b0, 1'b0, 11'h201,
                                          {16'h1000, 16'h8000, 16'h8000, 8'h80}, 3'd0));
      pending_frames.push_back(build_item(1'b0, 1'b0, 1'b0, 11'h201,
                                          {16'h2001, 16'h0001, 16'hFFFF, 8'h01}, 3'd0));
      pending_frames.push_back(build_item(1'b0, 1'b0, 1'b0, 11'h201,
                                          {16'h1001, 16'hFFFF, 16'h0001, 8'hFF}, 3'd0));
      pending_frames.push_back(build_item(1'b0, 1'b0, 1'b0, 11'h201, 56'h0, 3'd0));
      pending_frames.push_back(build_item(1'b0, 1'b0, 1'b0, 11'h208,
                                          {16'h7FFF, 16'h0000, 16'h0000, 8'h00}, 3'd0));
      pending_frames.push_back(build_item(1'b0, 1'b0, 1'b0, 11'h208,
                                          {16'h8000, 16'h1234, 16'hF000, 8'h40}, 3'd0));
      pending_frames.push_back(build_item(1'b0, 1'b0, 1'b0, 11'h202, '1, 3'd0));
      // Rejected frames: extended, remote and identifiers outside the window.
      pending_frames.push_back(build_item(1'b0, 1'b1, 1'b0, 11'h203, '1, 3'd7));
      pending_frames.push_back(build_item(1'b0, 1'b0, 1'b1, 11'h204, '1, 3'd7));
      pending_frames.push_back(build_item(1'b0, 1'b0, 1'b0, 11'h200, '1, 3'd0));
      pending_frames.push_back(build_item(1'b0, 1'b0, 1'b0, 11'h209, '1, 3'd0));
      pending_frames.push_back(build_item(1'b0, 1'b0, 1'b0, 11'h000, '1, 3'd0));
      pending_frames.push_back(build_item(1'b0, 1'b0, 1'b0, 11'h7FF, '1, 3'd0));
      // Clearing a total keeps the previous count.
      pending_frames.push_back(build_item(1'b1, 1'b0, 1'b0, 11'h000, 56'h0, 3'd0));
      pending_frames.push_back(build_item(1'b0, 1'b0, 1'b0, 11'h201,
                                          {16'h0010, 16'h0100, 16'h0100, 8'h10}, 3'd0));
      pending_frames.push_back(build_item(1'b1, 1'b1, 1'b1, 11'h7FF, '1, 3'd7));
      pending_frames.push_back(build_item(1'b0, 1'b0, 1'b0, 11'h208,
                                          {16'h8100, 16'hFF00, 16'h0080, 8'hC0}, 3'd0));
      for (int i = 2; i < 7; i++)
         pending_frames.push_back(build_item(1'b0, 1'b0, 1'b0, ID_FIRST + 11'(i),
                                             56'({$urandom, $urandom}), 3'($urandom)));
      wait_drained();

      run_phase(4'd3, 16'd256, 16'd65535, 0, 0, 100, 1'b1);
      run_phase(4'd8, 16'd65535, 16'd256, 51, 0, 100, 1'b0);
      // Ratios of zero and below one drive the divisions into saturation.
      run_phase(4'd15, 16'd0, 16'd100, 0, 51, 100, 1'b0);
      run_phase(4'd5, 16'd1, 16'd0, 21, 21, 100, 1'b0);
      run_phase(4'd0, 16'($urandom_range(65535, 256)), 16'($urandom_range(65535, 256)),
                0, 0, 100, 1'b0);

      if (error_count == 0 && expected_feedback.size() == 0) begin
         $display("tb_motor_feedback_frame_decoder: PASS");
      end else begin
         $display("tb_motor_feedback_frame_decoder: FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/mfd_pkg.sv
design/motor_feedback_frame_decoder.sv
verif/tb_motor_feedback_frame_decoder.sv
